FILE: sv/qsve_pkg.sv
package qsve_pkg;

    localparam int MAX_QUBITS    = 10;
    localparam int AMP_FRAC_BITS = 16;
    localparam int AMP_BITS      = AMP_FRAC_BITS + 2;
    localparam int DEPTH         = 1 << MAX_QUBITS;
    localparam int ADDR_W        = MAX_QUBITS;
    localparam int WORD_W        = 2 * AMP_BITS;
    localparam int QCNT_W        = 4;
    localparam int SQ_W          = 2 * AMP_BITS - 1;
    localparam int ACC_W         = SQ_W + 1 + MAX_QUBITS;
    localparam int PROD_W        = 51;
    localparam int FAC_W         = 32;
    localparam int FAC_FRAC      = 30;
    localparam int NORM_W        = 64;
    localparam int EXP_W         = 5;
    localparam int SQRT_STEPS    = NORM_W / 2;
    localparam int RECIP_BASE    = FAC_FRAC + AMP_FRAC_BITS;
    localparam int RND_W         = 16;
    localparam logic [QCNT_W-1:0] QCNT_RESET = QCNT_W'(MAX_QUBITS);
    // 1/sqrt(2) with 30 fraction bits
    localparam logic signed [PROD_W-1:0] H_COEF = PROD_W'(759250125);

    typedef logic signed [AMP_BITS-1:0] amp_t;

    localparam amp_t AMP_MAX = amp_t'((1 << (AMP_BITS - 1)) - 1);
    localparam amp_t AMP_MIN = amp_t'(1 << (AMP_BITS - 1));
    localparam amp_t AMP_ONE = amp_t'(1 << AMP_FRAC_BITS);

    typedef enum logic [2:0] {
        REQ_INIT, REQ_H, REQ_X, REQ_Z, REQ_S, REQ_CNOT, REQ_MEAS, REQ_READ
    } req_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef enum logic [4:0] {
        S_CLR_RST, S_IDLE, S_DECODE, S_CLR_INIT, S_RD_ADDR, S_RD_DATA,
        S_G_RA, S_G_RB, S_G_CB, S_G_MUL, S_G_WA, S_G_WB,
        S_M1_RD, S_M1_SQ, S_M1_ACC, S_M1_END,
        S_M2_RD, S_M2_SQ, S_M2_ACC, S_M2_END,
        S_M_NORM, S_M_SQRT, S_M_DIVI, S_M_DIV, S_M_FIN,
        S_M3_RD, S_M3_MUL, S_M3_WR, S_DONE
    } state_t;

    typedef enum logic [1:0] {AS_CNT, AS_PI, AS_PJ, AS_RIDX} addr_sel_t;

    typedef enum logic [2:0] {WD_CLEAR, WD_PI, WD_PJ, WD_ZERO, WD_SCALE} wd_sel_t;

    typedef struct packed {
        logic      latch;
        logic      cnt_clr;
        logic      cnt_inc;
        addr_sel_t rsel;
        logic      we;
        addr_sel_t wsel;
        wd_sel_t   wdsel;
        logic      cap_a;
        logic      cap_b;
        logic      gate_mul;
        logic      sq_calc;
        logic      acc_add;
        logic      acc_clr;
        logic      oc_set;
        logic      norm_load;
        logic      norm_shift;
        logic      sqrt_init;
        logic      sqrt_step;
        logic      div_init;
        logic      div_step;
        logic      div_final;
        logic      scale_mul;
        logic      rd_cap;
        logic      set_range;
        logic      set_zero;
        logic      res_load;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic range_err;
        logic pair_last;
        logic entry_last;
        logic clr_last;
        logic sqrt_last;
        logic div_last;
        logic acc_zero;
        logic norm_top;
        logic sel;
        logic out_free;
    } stat_t;

    // round v / 2^FAC_FRAC to nearest, ties away from zero, then saturate
    function automatic amp_t round_sat(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] q;
        amp_t              res;
        m = v[PROD_W-1] ? $unsigned(-v) : $unsigned(v);
        q = (m + (PROD_W'(1) << (FAC_FRAC - 1))) >> FAC_FRAC;
        if (v[PROD_W-1])
        begin
            if (q > (PROD_W'(1) << (AMP_BITS - 1)))
                res = AMP_MIN;
            else
                res = -$signed(q[AMP_BITS-1:0]);
        end
        else
        begin
            if (q > PROD_W'(AMP_MAX))
                res = AMP_MAX;
            else
                res = $signed(q[AMP_BITS-1:0]);
        end
        return res;
    endfunction

    function automatic amp_t neg_sat(input amp_t x);
        return (x == AMP_MIN) ? AMP_MAX : -x;
    endfunction

endpackage

FILE: sv/qsve_req_if.sv
interface qsve_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [3:0]  target_qubit;
    logic [3:0]  control_qubit;
    logic [15:0] random_value;
    logic [9:0]  read_index;

    modport source (output valid, req_type, target_qubit, control_qubit, random_value,
                    read_index, input ready);
    modport sink (input valid, req_type, target_qubit, control_qubit, random_value,
                  read_index, output ready);
endinterface

FILE: sv/qsve_res_if.sv
interface qsve_res_if;
    logic               valid;
    logic               ready;
    logic               outcome;
    logic signed [17:0] amp_real;
    logic signed [17:0] amp_imag;
    logic [1:0]         status;

    modport source (output valid, outcome, amp_real, amp_imag, status, input ready);
    modport sink (input valid, outcome, amp_real, amp_imag, status, output ready);
endinterface

FILE: sv/qsve_ram.sv
module qsve_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/qsve_ctrl.sv
module qsve_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qsve_pkg::stat_t  st,
    output qsve_pkg::cmd_t   cmd
);

    qsve_pkg::state_t state_reg;
    qsve_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qsve_pkg::S_CLR_RST;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qsve_pkg::S_CLR_RST:  if (st.clr_last) state_next = qsve_pkg::S_IDLE;
            qsve_pkg::S_IDLE:     if (in_valid) state_next = qsve_pkg::S_DECODE;
            qsve_pkg::S_DECODE:
            begin
                if (st.range_err)
                    state_next = qsve_pkg::S_DONE;
                else
                begin
                    case (st.req)
                        qsve_pkg::REQ_INIT: state_next = qsve_pkg::S_CLR_INIT;
                        qsve_pkg::REQ_READ: state_next = qsve_pkg::S_RD_ADDR;
                        qsve_pkg::REQ_MEAS: state_next = qsve_pkg::S_M1_RD;
                        default:            state_next = qsve_pkg::S_G_RA;
                    endcase
                end
            end
            qsve_pkg::S_CLR_INIT: if (st.clr_last) state_next = qsve_pkg::S_DONE;
            qsve_pkg::S_RD_ADDR:  state_next = qsve_pkg::S_RD_DATA;
            qsve_pkg::S_RD_DATA:  state_next = qsve_pkg::S_DONE;
            qsve_pkg::S_G_RA:     state_next = qsve_pkg::S_G_RB;
            qsve_pkg::S_G_RB:     state_next = qsve_pkg::S_G_CB;
            qsve_pkg::S_G_CB:     state_next = qsve_pkg::S_G_MUL;
            qsve_pkg::S_G_MUL:    state_next = qsve_pkg::S_G_WA;
            qsve_pkg::S_G_WA:     state_next = qsve_pkg::S_G_WB;
            qsve_pkg::S_G_WB:
                state_next = st.pair_last ? qsve_pkg::S_DONE : qsve_pkg::S_G_RA;
            qsve_pkg::S_M1_RD:    state_next = qsve_pkg::S_M1_SQ;
            qsve_pkg::S_M1_SQ:    state_next = qsve_pkg::S_M1_ACC;
            qsve_pkg::S_M1_ACC:
                state_next = st.entry_last ? qsve_pkg::S_M1_END : qsve_pkg::S_M1_RD;
            qsve_pkg::S_M1_END:   state_next = qsve_pkg::S_M2_RD;
            qsve_pkg::S_M2_RD:    state_next = qsve_pkg::S_M2_SQ;
            qsve_pkg::S_M2_SQ:    state_next = qsve_pkg::S_M2_ACC;
            qsve_pkg::S_M2_ACC:
                state_next = st.entry_last ? qsve_pkg::S_M2_END : qsve_pkg::S_M2_RD;
            qsve_pkg::S_M2_END:
                state_next = st.acc_zero ? qsve_pkg::S_DONE : qsve_pkg::S_M_NORM;
            qsve_pkg::S_M_NORM:   if (st.norm_top) state_next = qsve_pkg::S_M_SQRT;
            qsve_pkg::S_M_SQRT:   if (st.sqrt_last) state_next = qsve_pkg::S_M_DIVI;
            qsve_pkg::S_M_DIVI:   state_next = qsve_pkg::S_M_DIV;
            qsve_pkg::S_M_DIV:    if (st.div_last) state_next = qsve_pkg::S_M_FIN;
            qsve_pkg::S_M_FIN:    state_next = qsve_pkg::S_M3_RD;
            qsve_pkg::S_M3_RD:    state_next = qsve_pkg::S_M3_MUL;
            qsve_pkg::S_M3_MUL:   state_next = qsve_pkg::S_M3_WR;
            qsve_pkg::S_M3_WR:
                state_next = st.entry_last ? qsve_pkg::S_DONE : qsve_pkg::S_M3_RD;
            qsve_pkg::S_DONE:     if (st.out_free) state_next = qsve_pkg::S_IDLE;
            default:              state_next = qsve_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            qsve_pkg::S_CLR_RST, qsve_pkg::S_CLR_INIT:
            begin
                cmd.we      = 1'b1;
                cmd.wsel    = qsve_pkg::AS_CNT;
                cmd.wdsel   = qsve_pkg::WD_CLEAR;
                cmd.cnt_inc = 1'b1;
            end
            qsve_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            qsve_pkg::S_DECODE:
            begin
                cmd.cnt_clr   = 1'b1;
                cmd.set_range = st.range_err;
            end
            qsve_pkg::S_RD_ADDR: cmd.rsel = qsve_pkg::AS_RIDX;
            qsve_pkg::S_RD_DATA: cmd.rd_cap = 1'b1;
            qsve_pkg::S_G_RA:    cmd.rsel = qsve_pkg::AS_PI;
            qsve_pkg::S_G_RB:
            begin
                cmd.cap_a = 1'b1;
                cmd.rsel  = qsve_pkg::AS_PJ;
            end
            qsve_pkg::S_G_CB:    cmd.cap_b = 1'b1;
            qsve_pkg::S_G_MUL:   cmd.gate_mul = 1'b1;
            qsve_pkg::S_G_WA:
            begin
                cmd.we    = 1'b1;
                cmd.wsel  = qsve_pkg::AS_PI;
                cmd.wdsel = qsve_pkg::WD_PI;
            end
            qsve_pkg::S_G_WB:
            begin
                cmd.we      = 1'b1;
                cmd.wsel    = qsve_pkg::AS_PJ;
                cmd.wdsel   = qsve_pkg::WD_PJ;
                cmd.cnt_inc = !st.pair_last;
            end
            qsve_pkg::S_M1_RD, qsve_pkg::S_M2_RD, qsve_pkg::S_M3_RD:
                cmd.rsel = qsve_pkg::AS_CNT;
            qsve_pkg::S_M1_SQ, qsve_pkg::S_M2_SQ:
                cmd.sq_calc = 1'b1;
            qsve_pkg::S_M1_ACC:
            begin
                cmd.acc_add = 1'b1;
                cmd.cnt_inc = !st.entry_last;
            end
            qsve_pkg::S_M1_END:
            begin
                cmd.oc_set  = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.cnt_clr = 1'b1;
            end
            qsve_pkg::S_M2_ACC:
            begin
                // drop the entries that disagree with the outcome
                cmd.acc_add = 1'b1;
                cmd.we      = !st.sel;
                cmd.wsel    = qsve_pkg::AS_CNT;
                cmd.wdsel   = qsve_pkg::WD_ZERO;
                cmd.cnt_inc = !st.entry_last;
            end
            qsve_pkg::S_M2_END:
            begin
                cmd.norm_load = 1'b1;
                cmd.set_zero  = st.acc_zero;
            end
            qsve_pkg::S_M_NORM:
            begin
                cmd.sqrt_init  = st.norm_top;
                cmd.cnt_clr    = st.norm_top;
                cmd.norm_shift = !st.norm_top;
            end
            qsve_pkg::S_M_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
            end
            qsve_pkg::S_M_DIVI:
            begin
                cmd.div_init = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            qsve_pkg::S_M_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            qsve_pkg::S_M_FIN:
            begin
                cmd.div_final = 1'b1;
                cmd.cnt_clr   = 1'b1;
            end
            qsve_pkg::S_M3_MUL:  cmd.scale_mul = 1'b1;
            qsve_pkg::S_M3_WR:
            begin
                cmd.we      = 1'b1;
                cmd.wsel    = qsve_pkg::AS_CNT;
                cmd.wdsel   = qsve_pkg::WD_SCALE;
                cmd.cnt_inc = !st.entry_last;
            end
            qsve_pkg::S_DONE:    cmd.res_load = st.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

FILE: sv/qsve_dp.sv
module qsve_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qsve_pkg::QCNT_W-1:0]     cfg_data,
    input  logic [2:0]                      req_type,
    input  logic [3:0]                      target_qubit,
    input  logic [3:0]                      control_qubit,
    input  logic [qsve_pkg::RND_W-1:0]      random_value,
    input  logic [qsve_pkg::ADDR_W-1:0]     read_index,
    input  qsve_pkg::cmd_t                  cmd,
    output qsve_pkg::stat_t                 st,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic                            res_outcome,
    output qsve_pkg::amp_t                  res_amp_real,
    output qsve_pkg::amp_t                  res_amp_imag,
    output logic [1:0]                      res_status
);

    localparam int AW = qsve_pkg::ADDR_W;
    localparam int AB = qsve_pkg::AMP_BITS;
    localparam int PW = qsve_pkg::PROD_W;
    localparam int NW = qsve_pkg::NORM_W;
    localparam int FW = qsve_pkg::FAC_W;

    logic [qsve_pkg::QCNT_W-1:0] qcnt_reg;
    logic [3:0]                  n_eff;
    qsve_pkg::req_t              req_reg;
    logic [3:0]                  tq_reg;
    logic [3:0]                  cq_reg;
    logic [qsve_pkg::RND_W-1:0]  rnd_reg;
    logic [AW-1:0]               ridx_reg;

    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] size_m1;
    logic [AW-1:0] step;
    logic [AW-1:0] cstep;
    logic [AW-1:0] lowm;
    logic [AW-1:0] pair_i;
    logic [AW-1:0] pair_j;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [qsve_pkg::WORD_W-1:0] wdata;
    logic [qsve_pkg::WORD_W-1:0] rdata;
    qsve_pkg::amp_t rd_re;
    qsve_pkg::amp_t rd_im;

    qsve_pkg::amp_t a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [PW-1:0] pr0_reg, pr1_reg, pr2_reg, pr3_reg;
    logic signed [AB:0]   sum_re, sum_im, dif_re, dif_im;
    logic [qsve_pkg::WORD_W-1:0] res_i, res_j;
    logic swap;

    logic signed [qsve_pkg::SQ_W:0] sq_re_full, sq_im_full;
    logic [qsve_pkg::SQ_W-1:0]      sq_re_reg, sq_im_reg;
    logic                           sel_reg;
    logic                           pass2_reg;
    logic [qsve_pkg::ACC_W-1:0]     acc_reg;

    logic [NW-1:0]                  norm_reg;
    logic [qsve_pkg::EXP_W-1:0]     e_reg;
    logic [NW-1:0]                  x_reg, r_reg, bit_reg, sq_try;
    logic [FW-1:0]                  rem_reg, quo_reg, fac_reg, divisor;
    logic                           sat_reg;
    logic [FW:0]                    rem2, quo2, quo_rnd;

    logic                oc_reg;
    logic [1:0]          st_reg;
    qsve_pkg::amp_t      rre_reg, rim_reg;
    logic                out_valid_reg;
    logic                out_oc_reg;
    qsve_pkg::amp_t      out_re_reg, out_im_reg;
    logic [1:0]          out_st_reg;

    always_comb
    begin
        if (qcnt_reg == '0)
            n_eff = 4'd1;
        else if (qcnt_reg > qsve_pkg::QCNT_W'(qsve_pkg::MAX_QUBITS))
            n_eff = 4'(qsve_pkg::MAX_QUBITS);
        else
            n_eff = qcnt_reg;
    end

    assign size_m1 = AW'((((AW + 1)'(1)) << n_eff) - (AW + 1)'(1));
    assign step    = (tq_reg < n_eff) ? (AW'(1) << tq_reg) : '0;
    assign cstep   = (cq_reg < n_eff) ? (AW'(1) << cq_reg) : '0;
    assign lowm    = step - AW'(1);
    assign pair_i  = ((cnt_reg & ~lowm) << 1) | (cnt_reg & lowm);
    assign pair_j  = pair_i | step;

    always_comb
    begin
        st            = '0;
        st.req        = req_reg;
        st.range_err  = (req_reg != qsve_pkg::REQ_INIT) && (req_reg != qsve_pkg::REQ_READ)
                        && ((tq_reg >= n_eff)
                            || ((req_reg == qsve_pkg::REQ_CNOT) && (cq_reg >= n_eff)));
        st.pair_last  = (cnt_reg == (size_m1 >> 1));
        st.entry_last = (cnt_reg == size_m1);
        st.clr_last   = (cnt_reg == AW'(qsve_pkg::DEPTH - 1));
        st.sqrt_last  = (cnt_reg == AW'(qsve_pkg::SQRT_STEPS - 1));
        st.div_last   = (cnt_reg == AW'(qsve_pkg::RECIP_BASE - 1) + AW'(e_reg));
        st.acc_zero   = (acc_reg == '0);
        st.norm_top   = (norm_reg[NW-1:NW-2] != 2'b00);
        st.sel        = sel_reg;
        st.out_free   = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        case (cmd.rsel)
            qsve_pkg::AS_PI:   raddr = pair_i;
            qsve_pkg::AS_PJ:   raddr = pair_j;
            qsve_pkg::AS_RIDX: raddr = ridx_reg;
            default:           raddr = cnt_reg;
        endcase
        case (cmd.wsel)
            qsve_pkg::AS_PI:   waddr = pair_i;
            qsve_pkg::AS_PJ:   waddr = pair_j;
            qsve_pkg::AS_RIDX: waddr = ridx_reg;
            default:           waddr = cnt_reg;
        endcase
    end

    assign rd_re = rdata[qsve_pkg::WORD_W-1:AB];
    assign rd_im = rdata[AB-1:0];

    assign sum_re = (AB + 1)'(a_re_reg) + (AB + 1)'(b_re_reg);
    assign sum_im = (AB + 1)'(a_im_reg) + (AB + 1)'(b_im_reg);
    assign dif_re = (AB + 1)'(a_re_reg) - (AB + 1)'(b_re_reg);
    assign dif_im = (AB + 1)'(a_im_reg) - (AB + 1)'(b_im_reg);

    assign swap = (req_reg == qsve_pkg::REQ_X)
                  || ((req_reg == qsve_pkg::REQ_CNOT)
                      && ((cq_reg == tq_reg) || ((pair_i & cstep) != '0)));

    always_comb
    begin
        res_i = {a_re_reg, a_im_reg};
        res_j = {b_re_reg, b_im_reg};
        case (req_reg)
            qsve_pkg::REQ_H:
            begin
                res_i = {qsve_pkg::round_sat(pr0_reg), qsve_pkg::round_sat(pr1_reg)};
                res_j = {qsve_pkg::round_sat(pr2_reg), qsve_pkg::round_sat(pr3_reg)};
            end
            qsve_pkg::REQ_X, qsve_pkg::REQ_CNOT:
            begin
                if (swap)
                begin
                    res_i = {b_re_reg, b_im_reg};
                    res_j = {a_re_reg, a_im_reg};
                end
            end
            qsve_pkg::REQ_Z:
                res_j = {qsve_pkg::neg_sat(b_re_reg), qsve_pkg::neg_sat(b_im_reg)};
            qsve_pkg::REQ_S:
                res_j = {qsve_pkg::neg_sat(b_im_reg), b_re_reg};
            default:
            begin
                res_i = {a_re_reg, a_im_reg};
                res_j = {b_re_reg, b_im_reg};
            end
        endcase
    end

    always_comb
    begin
        case (cmd.wdsel)
            qsve_pkg::WD_CLEAR:
                wdata = (cnt_reg == '0) ? {qsve_pkg::AMP_ONE, AB'(0)} : '0;
            qsve_pkg::WD_PI:    wdata = res_i;
            qsve_pkg::WD_PJ:    wdata = res_j;
            qsve_pkg::WD_SCALE:
                wdata = {qsve_pkg::round_sat(pr0_reg), qsve_pkg::round_sat(pr1_reg)};
            default:            wdata = '0;
        endcase
    end

    qsve_ram #(
        .WIDTH (qsve_pkg::WORD_W),
        .DEPTH (qsve_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sq_re_full = (qsve_pkg::SQ_W + 1)'(rd_re) * (qsve_pkg::SQ_W + 1)'(rd_re);
    assign sq_im_full = (qsve_pkg::SQ_W + 1)'(rd_im) * (qsve_pkg::SQ_W + 1)'(rd_im);

    assign sq_try  = r_reg + bit_reg;
    assign divisor = r_reg[FW-1:0];
    assign rem2    = {rem_reg, 1'b0};
    assign quo2    = {quo_reg, (rem2 >= (FW + 1)'(divisor))};
    assign quo_rnd = (FW + 1)'(quo_reg) + (FW + 1)'(rem2 >= (FW + 1)'(divisor));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg      <= qsve_pkg::QCNT_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                qcnt_reg <= cfg_data;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + AW'(1);
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg   <= qsve_pkg::req_t'(req_type);
            tq_reg    <= target_qubit;
            cq_reg    <= control_qubit;
            rnd_reg   <= random_value;
            ridx_reg  <= read_index;
            oc_reg    <= 1'b0;
            st_reg    <= qsve_pkg::ST_OK;
            rre_reg   <= '0;
            rim_reg   <= '0;
            pass2_reg <= 1'b0;
            acc_reg   <= '0;
        end
        if (cmd.set_range)
            st_reg <= qsve_pkg::ST_RANGE;
        if (cmd.set_zero)
            st_reg <= qsve_pkg::ST_ZERO;
        if (cmd.rd_cap)
        begin
            rre_reg <= rd_re;
            rim_reg <= rd_im;
        end
        if (cmd.cap_a)
        begin
            a_re_reg <= rd_re;
            a_im_reg <= rd_im;
        end
        if (cmd.cap_b)
        begin
            b_re_reg <= rd_re;
            b_im_reg <= rd_im;
        end
        if (cmd.gate_mul)
        begin
            pr0_reg <= PW'(sum_re) * qsve_pkg::H_COEF;
            pr1_reg <= PW'(sum_im) * qsve_pkg::H_COEF;
            pr2_reg <= PW'(dif_re) * qsve_pkg::H_COEF;
            pr3_reg <= PW'(dif_im) * qsve_pkg::H_COEF;
        end
        if (cmd.scale_mul)
        begin
            pr0_reg <= PW'(rd_re) * $signed(PW'(fac_reg));
            pr1_reg <= PW'(rd_im) * $signed(PW'(fac_reg));
        end
        if (cmd.sq_calc)
        begin
            sq_re_reg <= sq_re_full[qsve_pkg::SQ_W-1:0];
            sq_im_reg <= sq_im_full[qsve_pkg::SQ_W-1:0];
            sel_reg   <= ((cnt_reg & step) != '0) == (pass2_reg ? oc_reg : 1'b1);
        end
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_add && sel_reg)
            acc_reg <= acc_reg + qsve_pkg::ACC_W'(sq_re_reg) + qsve_pkg::ACC_W'(sq_im_reg);
        if (cmd.oc_set)
        begin
            oc_reg    <= (qsve_pkg::ACC_W'(rnd_reg) << (2 * qsve_pkg::AMP_FRAC_BITS - 16))
                         < acc_reg;
            pass2_reg <= 1'b1;
        end
        if (cmd.norm_load)
        begin
            norm_reg <= NW'(acc_reg);
            e_reg    <= '0;
        end
        else if (cmd.norm_shift)
        begin
            norm_reg <= norm_reg << 2;
            e_reg    <= e_reg + qsve_pkg::EXP_W'(1);
        end
        if (cmd.sqrt_init)
        begin
            x_reg   <= norm_reg;
            r_reg   <= '0;
            bit_reg <= NW'(1) << (NW - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (x_reg >= sq_try)
            begin
                x_reg <= x_reg - sq_try;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            rem_reg <= FW'(1);
            quo_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= (rem2 >= (FW + 1)'(divisor)) ? FW'(rem2 - (FW + 1)'(divisor))
                                                    : rem2[FW-1:0];
            quo_reg <= quo2[FW-1:0];
            if (quo2[FW])
                sat_reg <= 1'b1;
        end
        if (cmd.div_final)
            fac_reg <= (sat_reg || quo_rnd[FW]) ? {FW{1'b1}} : quo_rnd[FW-1:0];
        if (cmd.res_load)
        begin
            out_oc_reg <= oc_reg;
            out_re_reg <= rre_reg;
            out_im_reg <= rim_reg;
            out_st_reg <= st_reg;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_outcome  = out_oc_reg;
    assign res_amp_real = out_re_reg;
    assign res_amp_imag = out_im_reg;
    assign res_status   = out_st_reg;

endmodule

FILE: sv/qubit_state_vector_engine.sv
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, target_qubit, control_qubit, random_value, read_index
// res      out  valid/ready    outcome, amp_real, amp_imag, status
// cfg      in   cfg_we         cfg_data (qubit_count)
//
// One request at a time; amplitudes share one store with a read and a write port, size = 2^n.
// Gates read, transform and write back each amplitude pair; init clears the whole store.
// Read returns one stored amplitude. Measure makes three passes over the entries (sum the
// target-one probability, zero the disagreeing entries, rescale) around norm and 1/sqrt steps.
// After reset a sweep clears the store; ready stays low until it ends.
// A finished result waits in the output register while the next request is taken.
module qubit_state_vector_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    qsve_req_if.sink                    req,
    qsve_res_if.source                  res,
    input  logic                        cfg_we,
    input  logic [qsve_pkg::QCNT_W-1:0] cfg_data
);

    qsve_pkg::cmd_t  cmd;
    qsve_pkg::stat_t st;
    logic            in_ready;

    assign req.ready = in_ready;

    qsve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    qsve_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_type      (req.req_type),
        .target_qubit  (req.target_qubit),
        .control_qubit (req.control_qubit),
        .random_value  (req.random_value),
        .read_index    (req.read_index),
        .cmd           (cmd),
        .st            (st),
        .res_ready     (res.ready),
        .res_valid     (res.valid),
        .res_outcome   (res.outcome),
        .res_amp_real  (res.amp_real),
        .res_amp_imag  (res.amp_imag),
        .res_status    (res.status)
    );

endmodule
